// ----- rtl/core/rc4_pkg.sv -----
// rc4 cipher package: widths, register codes, fsm states and key select type
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int PERM_ADDR_W   = $clog2(PERM_DEPTH);
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

    localparam logic KIND_REKEY = 1'b0;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_INIT   = 9'b000000010,
        ST_KS_A   = 9'b000000100,
        ST_KS_B   = 9'b000001000,
        ST_KS_C   = 9'b000010000,
        ST_KS_D   = 9'b000100000,
        ST_DT_J   = 9'b001000000,
        ST_DT_T   = 9'b010000000,
        ST_DT_OUT = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_wrap;
    } key_sel_t;

endpackage

// ----- rtl/core/rc4_stream_cipher.sv -----
// rc4 stream cipher top level: permutation memory, schedule and keystream fsm
//
// usage: write the key length (index 0) and key words (index 1..4) on the cfg
// channel while the block is idle, then send an input beat with kind = 0 to
// run the key schedule. each input beat with kind = 1 gives one output beat
// holding data_byte xor the next keystream byte. data beats sent before the
// first rekey are taken and dropped.
// a data beat taken from idle runs through st_dt_j, st_dt_t and st_dt_out,
// which loads the output register. the single permutation memory does three
// reads and two writes per data byte; the next byte's first read is shared
// with the last write: st_dt_out takes a new beat if the output is free.
// rekey: an identity fill of the memory, then the key walk st_ks_a to
// st_ks_d for each entry; no input beat is taken during it.
// the output register holds one result; while the receiver stalls, one more
// data beat can be taken and run up to its last step, where the block then
// waits with in_ready low.
// reset clears the counters, the keyed flag and the key words, sets the key
// length to 1; the memory is only defined after the first rekey.
`timescale 1ns / 1ps

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [KEY_WORD_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte
);

    state_t                 state_reg, state_next;
    logic [PERM_ADDR_W-1:0] cnt_reg, cnt_next;
    logic [KEY_IDX_W-1:0]   kidx_reg, kidx_next;
    logic [7:0]             i_reg, i_next;
    logic [7:0]             j_reg, j_next;
    logic [7:0]             si_reg, si_next;
    logic [7:0]             sj_reg, sj_next;
    logic [7:0]             data_reg, data_next;
    logic                   fwd_reg, fwd_next;
    logic                   keyed_reg, keyed_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;

    logic [7:0]             perm_mem [PERM_DEPTH];
    logic                   mem_rd_en;
    logic [PERM_ADDR_W-1:0] mem_rd_addr;
    logic [7:0]             mem_rd_data_reg;
    logic                   mem_wr_en;
    logic [PERM_ADDR_W-1:0] mem_wr_addr;
    logic [7:0]             mem_wr_data;

    key_sel_t               key_sel;
    logic                   in_fire;
    logic                   out_free;
    logic [7:0]             i_inc;
    logic [7:0]             si_cur;
    logic [7:0]             j_sum;
    logic [7:0]             t_idx;
    logic [7:0]             ks_byte;

    rc4_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kidx      (kidx_reg),
        .key_sel   (key_sel)
    );

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            perm_mem[mem_wr_addr] <= mem_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
            mem_rd_data_reg <= perm_mem[mem_rd_addr];
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DT_OUT) && out_free);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    assign i_inc  = i_reg + 8'd1;
    assign si_cur = fwd_reg ? si_reg : mem_rd_data_reg;
    assign t_idx  = si_reg + sj_reg;

    // keystream byte after both swaps of the current step
    always_comb
    begin
        if (t_idx == j_reg)
            ks_byte = si_reg;
        else if (t_idx == i_reg)
            ks_byte = sj_reg;
        else
            ks_byte = mem_rd_data_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kidx_next      = kidx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        data_next      = data_reg;
        fwd_next       = fwd_reg;
        keyed_next     = keyed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = cnt_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cnt_reg;
        mem_wr_data    = cnt_reg;
        j_sum          = j_reg + mem_rd_data_reg + key_sel.key_byte;

        case (state_reg)
            ST_IDLE: ;
            ST_INIT:
            begin
                mem_wr_en = 1'b1;
                if (cnt_reg == PERM_ADDR_W'(PERM_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_A;
                end
                else
                    cnt_next = cnt_reg + PERM_ADDR_W'(1);
            end
            ST_KS_A:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_KS_B;
            end
            ST_KS_B:
            begin
                j_next      = j_sum;
                si_next     = mem_rd_data_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_sum;
                kidx_next   = key_sel.key_wrap ? '0 : kidx_reg + KEY_IDX_W'(1);
                state_next  = ST_KS_C;
            end
            ST_KS_C:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data_reg;
                state_next  = ST_KS_D;
            end
            ST_KS_D:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = j_reg;
                mem_wr_data = si_reg;
                if (cnt_reg == PERM_ADDR_W'(PERM_DEPTH - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + PERM_ADDR_W'(1);
                    state_next = ST_KS_A;
                end
            end
            ST_DT_J:
            begin
                si_next     = si_cur;
                j_next      = j_reg + si_cur;
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_reg + si_cur;
                state_next  = ST_DT_T;
            end
            ST_DT_T:
            begin
                sj_next     = mem_rd_data_reg;
                mem_wr_en   = 1'b1;
                mem_wr_addr = i_reg;
                mem_wr_data = mem_rd_data_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = si_reg + mem_rd_data_reg;
                state_next  = ST_DT_OUT;
            end
            ST_DT_OUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = j_reg;
                mem_wr_data = si_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // new beat, taken from idle or overlapped with the last write
        if (in_fire)
        begin
            if (kind == KIND_REKEY)
            begin
                cnt_next   = '0;
                j_next     = '0;
                state_next = ST_INIT;
            end
            else if (keyed_reg)
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = i_inc;
                i_next      = i_inc;
                data_next   = data_byte;
                fwd_next    = (state_reg == ST_DT_OUT) && (j_reg == i_inc);
                state_next  = ST_DT_J;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kidx_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            fwd_reg       <= 1'b0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kidx_reg      <= kidx_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            fwd_reg       <= fwd_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

// ----- rtl/core/rc4_cfg.sv -----
// rc4 configuration registers and key byte selection
`timescale 1ns / 1ps

module rc4_cfg
    import rc4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [KEY_WORD_W-1:0]  cfg_data,
    input  logic [KEY_IDX_W-1:0]   kidx,
    output key_sel_t               key_sel
);

    logic [KEY_LEN_W-1:0]  key_len_reg;
    logic [KEY_WORD_W-1:0] key_word_reg [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  len_m1;
    logic [KEY_IDX_W-1:0]  key_last;
    logic [5:0]            bit_ofs;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg     <= KEY_LEN_W'(1);
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LEN:    key_len_reg     <= cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                CFG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                CFG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                CFG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective length clamped to 1..MAX_KEY_BYTES, kept as last index
    assign len_m1 = key_len_reg - KEY_LEN_W'(1);

    always_comb
    begin
        if (key_len_reg == '0)
            key_last = '0;
        else if (key_len_reg > KEY_LEN_W'(MAX_KEY_BYTES))
            key_last = KEY_IDX_W'(MAX_KEY_BYTES - 1);
        else
            key_last = len_m1[KEY_IDX_W-1:0];
    end

    assign bit_ofs = {kidx[2:0], 3'b000};

    assign key_sel.key_byte = key_word_reg[kidx[KEY_IDX_W-1:3]][bit_ofs +: 8];
    assign key_sel.key_wrap = (kidx == key_last);

endmodule
